>>> hw/rtl/ptcm_pkg.sv
// Shared widths, constants and types of the planar texture coordinate map.
`timescale 1ns / 1ps

package ptcm_pkg;

  // Field widths of the channels and the register.
  localparam int NORM_W = 16;
  localparam int HIT_W  = 32;
  localparam int TILE_W = 16;
  localparam int TEX_W  = 16;

  // Internal arithmetic widths.
  localparam int SQ_W      = 32;             // squared lengths and their roots
  localparam int UQ_W      = 30;             // magnitude of a unit component
  localparam int UNIT_W    = UQ_W + 1;       // signed unit component, Q.28
  localparam int UNIT_FRAC = 28;
  localparam int PROD_W    = UNIT_W + HIT_W; // one term of a projection
  localparam int SUM_W     = 64;             // a full projection

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam logic [TILE_W-1:0] TILE_RESET = 16'd768;
  localparam logic [TILE_W-1:0] TILE_MIN   = 16'd1;

  localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) <<< UNIT_FRAC;

  typedef struct packed {
    logic zero;   // all three normal components are zero
    logic axis;   // normal lies along z
    logic nz_pos; // z component is strictly positive
  } ptcm_flags_t;

endpackage

>>> hw/rtl/ptcm_isqrt_pipe.sv
// Pipelined integer square root, one result bit resolved per stage.
`timescale 1ns / 1ps

module ptcm_isqrt_pipe #(
  parameter int XW = 64,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [XW-1:0]       x_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [XW/2-1:0]     root_o,
  output logic [SW-1:0]       side_o
);

  localparam int RW = XW / 2;

  logic          vld_r  [RW];
  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [XW-1:0] x_r    [RW];
  logic [SW-1:0] side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          vld_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [SW-1:0] side_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] diff;
    logic          ge;
    logic [RW+1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down the next two bits and try subtracting 4*root + 1.
    assign cur      = {rem_in, x_in[XW-1 -: 2]};
    assign diff     = cur - {2'b00, root_in, 2'b01};
    assign ge       = !diff[RW+3];
    assign rem_nxt  = ge ? diff[RW+1:0] : cur[RW+1:0];
    assign root_nxt = {root_in[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        x_r[k]    <= {x_in[XW-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

>>> hw/rtl/ptcm_div_pipe.sv
// Pipelined restoring divider, one quotient bit resolved per stage.
`timescale 1ns / 1ps

module ptcm_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,  // upper dividend part, below the divisor
  input  logic [QW-1:0] bits_i, // lower dividend bits, one per stage
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] word_r [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] word_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign word_in = bits_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign word_in = word_r[k-1];
      assign side_in = side_r[k-1];
    end

    // The word shifts left: dividend bits leave at the top, quotient bits enter below.
    assign cur     = {rem_in, word_in[QW-1]};
    assign diff    = cur - {1'b0, den_in};
    assign rem_nxt = diff[DW] ? cur[DW-1:0] : diff[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        word_r[k] <= {word_in[QW-2:0], !diff[DW]};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign quot_o = word_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

>>> hw/rtl/planar_texture_coord_map.sv
// Top level of the planar texture coordinate map pipeline.
`timescale 1ns / 1ps

// Maps a ray hit on a plane to folded texture coordinates. Each input
// transaction carries the plane normal (signed Q2.14) and the hit point
// (signed Q16.16); each output transaction carries tex_u and tex_v (unsigned
// Q0.16) and a flag that marks an all-zero normal, in which case both
// coordinates are zero. Exactly one output transaction follows every input
// transaction, in order.
// Both channels use valid and stall. The tile size register is written through
// cfg_wr_en and cfg_wr_data and should only change while the pipeline is empty.
// Throughput is one transaction per cycle unless a held output stalls the
// pipeline. Its stages are those of three bit-serial pipelines, the square
// root stages (32), the unit-vector dividers (30) and the tile dividers
// (59 - COORD_FRAC_BITS), plus seven arithmetic and register stages.
// The whole pipeline advances on a single enable; when the output register
// holds a transaction and out_stall is high, every stage holds and in_stall
// is raised, so nothing is lost or repeated.
// Synchronous reset clears every valid bit and restores a tile size of 3.0.

module planar_texture_coord_map #(
  parameter int COORD_FRAC_BITS = ptcm_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ptcm_pkg::TILE_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ptcm_pkg::NORM_W-1:0]  in_normal_x,
  input  logic signed [ptcm_pkg::NORM_W-1:0]  in_normal_y,
  input  logic signed [ptcm_pkg::NORM_W-1:0]  in_normal_z,
  input  logic signed [ptcm_pkg::HIT_W-1:0]   in_hit_x,
  input  logic signed [ptcm_pkg::HIT_W-1:0]   in_hit_y,
  input  logic signed [ptcm_pkg::HIT_W-1:0]   in_hit_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ptcm_pkg::TEX_W-1:0]          out_tex_u,
  output logic [ptcm_pkg::TEX_W-1:0]          out_tex_v,
  output logic                                out_zero_normal
);

  import ptcm_pkg::*;

  // The tile divisor is tile_size scaled by 2^(4+COORD_FRAC_BITS); the shift
  // is applied to the projection magnitude instead, leaving a 16-bit divisor.
  localparam int SH = 4 + COORD_FRAC_BITS;
  localparam int QW = PROD_W - SH;
  localparam int HITS_W = 3 * HIT_W;
  localparam int SIDE_A_W = $bits(ptcm_flags_t) + 3 * NORM_W;

  logic en;

  // Configuration register.
  logic [TILE_W-1:0] tile_r;
  logic [TILE_W-1:0] tile_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r <= TILE_RESET;
    end else if (cfg_wr_en) begin
      tile_r <= cfg_wr_data;
    end
  end

  // A tile size of zero behaves as the smallest step.
  assign tile_eff = (tile_r == '0) ? TILE_MIN : tile_r;

  // The output register is the only place a finished transaction waits, so
  // the pipeline moves whenever it is empty or being emptied.
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage A: squared lengths of the normal and its xy part.
  logic signed [2*NORM_W-1:0] sqx, sqy, sqz;
  logic [SQ_W-1:0]            r2_nxt, n2_nxt;
  ptcm_flags_t                flags_nxt;

  logic                       a_vld_r;
  logic [SQ_W-1:0]            a_r2_r, a_n2_r;
  logic signed [NORM_W-1:0]   a_nx_r, a_ny_r, a_nz_r;
  logic [HITS_W-1:0]          a_hits_r;
  ptcm_flags_t                a_flags_r;

  assign sqx    = in_normal_x * in_normal_x;
  assign sqy    = in_normal_y * in_normal_y;
  assign sqz    = in_normal_z * in_normal_z;
  assign r2_nxt = SQ_W'($unsigned(sqx)) + SQ_W'($unsigned(sqy));
  assign n2_nxt = r2_nxt + SQ_W'($unsigned(sqz));

  always_comb begin
    flags_nxt.axis   = (in_normal_x == '0) && (in_normal_y == '0);
    flags_nxt.zero   = flags_nxt.axis && (in_normal_z == '0);
    flags_nxt.nz_pos = !in_normal_z[NORM_W-1] && (in_normal_z != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
    if (en) begin
      a_r2_r    <= r2_nxt;
      a_n2_r    <= n2_nxt;
      a_nx_r    <= in_normal_x;
      a_ny_r    <= in_normal_y;
      a_nz_r    <= in_normal_z;
      a_hits_r  <= {in_hit_x, in_hit_y, in_hit_z};
      a_flags_r <= flags_nxt;
    end
  end

  // Square roots of r2 * 2^32 and n2 * 2^32, giving lengths in Q.30.
  logic                  sa_vld, sb_vld;
  logic [SQ_W-1:0]       rs, ns;
  logic [SIDE_A_W-1:0]   sa_side;
  logic [HITS_W-1:0]     sb_hits;

  ptcm_isqrt_pipe #(.XW(2 * SQ_W), .SW(SIDE_A_W)) u_sqrt_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (a_vld_r),
    .x_i    ({a_r2_r, {SQ_W{1'b0}}}),
    .side_i ({a_flags_r, a_nx_r, a_ny_r, a_nz_r}),
    .vld_o  (sa_vld),
    .root_o (rs),
    .side_o (sa_side)
  );

  ptcm_isqrt_pipe #(.XW(2 * SQ_W), .SW(HITS_W)) u_sqrt_n (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (a_vld_r),
    .x_i    ({a_n2_r, {SQ_W{1'b0}}}),
    .side_i (a_hits_r),
    .vld_o  (sb_vld),
    .root_o (ns),
    .side_o (sb_hits)
  );

  // Stage B: the unit components as magnitudes, each numerator shifted so that
  // its upper part already lies below the divisor.
  ptcm_flags_t              b_flags;
  logic signed [NORM_W-1:0] b_nx, b_ny, b_nz;
  logic [NORM_W-1:0]        abs_x, abs_y, abs_z;
  logic                     b_vld;

  assign {b_flags, b_nx, b_ny, b_nz} = sa_side;
  assign b_vld = sa_vld && sb_vld;
  assign abs_x = b_nx[NORM_W-1] ? NORM_W'(-b_nx) : NORM_W'(b_nx);
  assign abs_y = b_ny[NORM_W-1] ? NORM_W'(-b_ny) : NORM_W'(b_ny);
  assign abs_z = b_nz[NORM_W-1] ? NORM_W'(-b_nz) : NORM_W'(b_nz);

  logic              dx_vld, dy_vld, dz_vld, dr_vld;
  logic [UQ_W-1:0]   qx, qy, qz, qr;
  logic [3:0]        dx_side;
  logic              dy_side, dz_side;
  logic [HITS_W-1:0] dr_hits;

  ptcm_div_pipe #(.DW(SQ_W), .QW(UQ_W), .SW(4)) u_div_cx (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld),
    .rem_i  ({2'b00, abs_x, 14'b0}),
    .bits_i ('0),
    .den_i  (rs),
    .side_i ({b_flags, b_nx[NORM_W-1]}),
    .vld_o  (dx_vld),
    .quot_o (qx),
    .side_o (dx_side)
  );

  ptcm_div_pipe #(.DW(SQ_W), .QW(UQ_W), .SW(1)) u_div_cy (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld),
    .rem_i  ({2'b00, abs_y, 14'b0}),
    .bits_i ('0),
    .den_i  (rs),
    .side_i (b_ny[NORM_W-1]),
    .vld_o  (dy_vld),
    .quot_o (qy),
    .side_o (dy_side)
  );

  ptcm_div_pipe #(.DW(SQ_W), .QW(UQ_W), .SW(1)) u_div_sz (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld),
    .rem_i  ({2'b00, abs_z, 14'b0}),
    .bits_i ('0),
    .den_i  (ns),
    .side_i (b_nz[NORM_W-1]),
    .vld_o  (dz_vld),
    .quot_o (qz),
    .side_o (dz_side)
  );

  // rn = rs * 2^28 / ns, the z component of the horizontal axis.
  ptcm_div_pipe #(.DW(SQ_W), .QW(UQ_W), .SW(HITS_W)) u_div_rn (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld),
    .rem_i  ({2'b00, rs[SQ_W-1:2]}),
    .bits_i ({rs[1:0], {UNIT_FRAC{1'b0}}}),
    .den_i  (ns),
    .side_i (sb_hits),
    .vld_o  (dr_vld),
    .quot_o (qr),
    .side_o (dr_hits)
  );

  // Stage C: products sz * cx and sz * cy as magnitudes.
  logic                c_vld_r;
  logic [2*UQ_W-1:0]   c_mx_r, c_my_r;
  logic [UQ_W-1:0]     c_qx_r, c_qy_r, c_qr_r;
  logic                c_snx_r, c_sny_r, c_snz_r;
  ptcm_flags_t         c_flags_r;
  logic [HITS_W-1:0]   c_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= dx_vld && dy_vld && dz_vld && dr_vld;
    end
    if (en) begin
      c_mx_r    <= qz * qx;
      c_my_r    <= qz * qy;
      c_qx_r    <= qx;
      c_qy_r    <= qy;
      c_qr_r    <= qr;
      c_flags_r <= dx_side[3:1];
      c_snx_r   <= dx_side[0];
      c_sny_r   <= dy_side;
      c_snz_r   <= dz_side;
      c_hits_r  <= dr_hits;
    end
  end

  // Stage D: signed axes, with the normal along z taking the fixed basis.
  logic [UQ_W-1:0]          mag_ux, mag_uy;
  logic signed [UNIT_W-1:0] pqx, pqy, pux, puy;
  logic signed [UNIT_W-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt;

  logic                     d_vld_r;
  logic signed [UNIT_W-1:0] d_ux_r, d_uy_r, d_uz_r, d_vx_r, d_vy_r;
  logic                     d_zero_r;
  logic [HITS_W-1:0]        d_hits_r;

  assign mag_ux = c_mx_r[UNIT_FRAC +: UQ_W];
  assign mag_uy = c_my_r[UNIT_FRAC +: UQ_W];
  assign pqx    = $signed({1'b0, c_qx_r});
  assign pqy    = $signed({1'b0, c_qy_r});
  assign pux    = $signed({1'b0, mag_ux});
  assign puy    = $signed({1'b0, mag_uy});

  always_comb begin
    if (c_flags_r.axis) begin
      vx_nxt = '0;
      vy_nxt = UNIT_ONE;
      ux_nxt = c_flags_r.nz_pos ? -UNIT_ONE : UNIT_ONE;
      uy_nxt = '0;
      uz_nxt = '0;
    end else begin
      vx_nxt = c_sny_r ? pqy : -pqy;
      vy_nxt = c_snx_r ? -pqx : pqx;
      ux_nxt = (c_snz_r ^ c_snx_r) ? pux : -pux;
      uy_nxt = (c_snz_r ^ c_sny_r) ? puy : -puy;
      uz_nxt = $signed({1'b0, c_qr_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
    if (en) begin
      d_ux_r   <= ux_nxt;
      d_uy_r   <= uy_nxt;
      d_uz_r   <= uz_nxt;
      d_vx_r   <= vx_nxt;
      d_vy_r   <= vy_nxt;
      d_zero_r <= c_flags_r.zero;
      d_hits_r <= c_hits_r;
    end
  end

  // Stage E: the five projection terms.
  logic signed [HIT_W-1:0]  d_hx, d_hy, d_hz;
  logic                     e_vld_r;
  logic signed [PROD_W-1:0] e_pux_r, e_puy_r, e_puz_r, e_pvx_r, e_pvy_r;
  logic                     e_zero_r;

  assign {d_hx, d_hy, d_hz} = d_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
    if (en) begin
      e_pux_r  <= d_ux_r * d_hx;
      e_puy_r  <= d_uy_r * d_hy;
      e_puz_r  <= d_uz_r * d_hz;
      e_pvx_r  <= d_vx_r * d_hx;
      e_pvy_r  <= d_vy_r * d_hy;
      e_zero_r <= d_zero_r;
    end
  end

  // Stage F: projections on both axes.
  logic                    f_vld_r;
  logic signed [SUM_W-1:0] f_su_r, f_sv_r;
  logic                    f_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
    if (en) begin
      f_su_r   <= SUM_W'(e_pux_r) + SUM_W'(e_puy_r) + SUM_W'(e_puz_r);
      f_sv_r   <= SUM_W'(e_pvx_r) + SUM_W'(e_pvy_r);
      f_zero_r <= e_zero_r;
    end
  end

  // Stage G: magnitude and sign of each projection, pre-scaled for the tile.
  logic [SUM_W-1:0] mag_u, mag_v;
  logic             g_vld_r;
  logic [QW-1:0]    g_nu_r, g_nv_r;
  logic             g_pos_u_r, g_pos_v_r, g_zero_r;

  assign mag_u = f_su_r[SUM_W-1] ? SUM_W'(-f_su_r) : SUM_W'(f_su_r);
  assign mag_v = f_sv_r[SUM_W-1] ? SUM_W'(-f_sv_r) : SUM_W'(f_sv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
    if (en) begin
      g_nu_r    <= mag_u[PROD_W-1:SH];
      g_nv_r    <= mag_v[PROD_W-1:SH];
      g_pos_u_r <= !f_su_r[SUM_W-1] && (f_su_r != '0);
      g_pos_v_r <= !f_sv_r[SUM_W-1] && (f_sv_r != '0);
      g_zero_r  <= f_zero_r;
    end
  end

  // Tile division of both coordinates.
  logic          fu_vld, fv_vld;
  logic [QW-1:0] qu, qv;
  logic [1:0]    fu_side;
  logic          fv_side;

  ptcm_div_pipe #(.DW(TILE_W), .QW(QW), .SW(2)) u_div_tu (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (g_vld_r),
    .rem_i  ('0),
    .bits_i (g_nu_r),
    .den_i  (tile_eff),
    .side_i ({g_zero_r, g_pos_u_r}),
    .vld_o  (fu_vld),
    .quot_o (qu),
    .side_o (fu_side)
  );

  ptcm_div_pipe #(.DW(TILE_W), .QW(QW), .SW(1)) u_div_tv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (g_vld_r),
    .rem_i  ('0),
    .bits_i (g_nv_r),
    .den_i  (tile_eff),
    .side_i (g_pos_v_r),
    .vld_o  (fv_vld),
    .quot_o (qv),
    .side_o (fv_side)
  );

  // Output stage: fold the fraction, zeroed for a zero normal. A non-zero
  // fraction f of a positive projection becomes 1 - f and needs no clamp.
  logic [TEX_W-1:0] fr_u, fr_v, tex_u_nxt, tex_v_nxt;
  logic [TEX_W-1:0] tex_u_r, tex_v_r;
  logic             zero_r;

  assign fr_u = qu[TEX_W-1:0];
  assign fr_v = qv[TEX_W-1:0];

  always_comb begin
    tex_u_nxt = (fu_side[0] && fr_u != '0) ? TEX_W'(0) - fr_u : fr_u;
    tex_v_nxt = (fv_side && fr_v != '0) ? TEX_W'(0) - fr_v : fr_v;
    if (fu_side[1]) begin
      tex_u_nxt = '0;
      tex_v_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fu_vld && fv_vld;
    end
    if (en) begin
      tex_u_r <= tex_u_nxt;
      tex_v_r <= tex_v_nxt;
      zero_r  <= fu_side[1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_zero_normal = zero_r;

endmodule

>>> hw/rtl/ptcm_checker.sv
// Port-level assertions for the planar texture coordinate map, with its bind.
`timescale 1ns / 1ps

module ptcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ptcm_pkg::TEX_W-1:0]  out_tex_u,
  input logic [ptcm_pkg::TEX_W-1:0]  out_tex_v,
  input logic                        out_zero_normal
);

  import ptcm_pkg::*;

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input is held back exactly when a finished transaction is blocked.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the blocked output");

  // A zero normal always carries zero coordinates.
  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_normal) |-> (out_tex_u == '0 && out_tex_v == '0))
    else $error("zero normal with non-zero coordinates");

  // A blocked result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_tex_u) && $stable(out_tex_v) && $stable(out_zero_normal)))
    else $error("blocked result changed");

endmodule

bind planar_texture_coord_map ptcm_checker u_ptcm_checker (.*);

>>> dv/tb_planar_texture_coord_map.sv
// Self-checking testbench for the planar texture coordinate map.
`timescale 1ns / 1ps

module tb_planar_texture_coord_map;
  import ptcm_pkg::*;

  localparam int FRAC       = COORD_FRAC_BITS_DEF;
  // Pipeline depth from the top-level description, with some margin.
  localparam int DRAIN      = 140;
  localparam int WATCH_MAX  = 20000;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 285;

  typedef struct {
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [HIT_W-1:0]  hx, hy, hz;
  } hit_item_t;

  typedef struct {
    logic [TEX_W-1:0] u, v;
    logic             zero;
  } tex_coord_t;

  typedef struct {
    hit_item_t  item;
    bit         typed;   // expectation written by hand in the table
    tex_coord_t want;
  } plane_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [TILE_W-1:0]        cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [NORM_W-1:0] in_normal_x, in_normal_y, in_normal_z;
  logic signed [HIT_W-1:0]  in_hit_x, in_hit_y, in_hit_z;
  logic                     out_valid;
  logic                     out_stall;
  logic [TEX_W-1:0]         out_tex_u, out_tex_v;
  logic                     out_zero_normal;

  planar_texture_coord_map dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_hit_x(in_hit_x), .in_hit_y(in_hit_y), .in_hit_z(in_hit_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_zero_normal(out_zero_normal)
  );

  // The tile size the block is believed to hold, and the coordinates still owed.
  logic [TILE_W-1:0] tile_now;
  tex_coord_t        coords_owed[$];
  int                n_sent;
  int                n_checked;
  int                n_errors;
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer square root, rounded down, by the classic bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Division that truncates toward zero, with an unsigned divisor.
  function automatic longint div_toward_zero(longint num, longint unsigned den);
    longint unsigned q;
    q = magnitude(num) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Folds the fractional tile position into a mirrored Q0.16 coordinate.
  function automatic logic [TEX_W-1:0] fold_coord(longint p, longint unsigned den);
    longint unsigned f;
    longint unsigned r;
    f = (magnitude(p) / den) & 64'hFFFF;
    r = (p > 0 && f != 0) ? 64'd65536 - f : f;
    if (r > 64'd65535) r = 64'd65535;
    return r[TEX_W-1:0];
  endfunction

  function automatic tex_coord_t map_hit(hit_item_t it, logic [TILE_W-1:0] tile);
    longint          nx, ny, nz, hx, hy, hz;
    longint          ux, uy, uz, vx, vy, cx, cy, sz;
    longint unsigned r2, n2, rs, ns, den, t;
    tex_coord_t      res;
    nx = it.nx; ny = it.ny; nz = it.nz;
    hx = it.hx; hy = it.hy; hz = it.hz;
    r2 = nx * nx + ny * ny;
    n2 = r2 + nz * nz;
    res.zero = 1'b0;
    if (n2 == 0) begin
      res.u = '0;
      res.v = '0;
      res.zero = 1'b1;
      return res;
    end
    if (r2 == 0) begin
      // Normal along z: the basis is fixed up to the sign of z.
      vx = 0;
      vy = longint'(1) <<< 28;
      ux = (nz > 0) ? -(longint'(1) <<< 28) : (longint'(1) <<< 28);
      uy = 0;
      uz = 0;
    end else begin
      rs = floor_sqrt(r2 << 32);
      ns = floor_sqrt(n2 << 32);
      cx = div_toward_zero(nx * (longint'(1) <<< 44), rs);
      cy = div_toward_zero(ny * (longint'(1) <<< 44), rs);
      sz = div_toward_zero(nz * (longint'(1) <<< 44), ns);
      vx = -cy;
      vy = cx;
      ux = -div_toward_zero(sz * cx, 64'd1 << 28);
      uy = -div_toward_zero(sz * cy, 64'd1 << 28);
      uz = div_toward_zero(longint'(rs << 28), ns);
    end
    t = (tile == 0) ? 64'd1 : 64'(tile);
    den = t << (4 + FRAC);
    res.u = fold_coord(ux * hx + uy * hy + uz * hz, den);
    res.v = fold_coord(vx * hx + vy * hy, den);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic hit_item_t random_hit();
    hit_item_t it;
    int        kind;
    kind = $urandom_range(0, 19);
    it.nx = NORM_W'($urandom);
    it.ny = NORM_W'($urandom);
    it.nz = NORM_W'($urandom);
    if (kind < 3) begin
      // Axis-aligned normal, z of either sign (occasionally zero too).
      it.nx = '0;
      it.ny = '0;
    end else if (kind == 3) begin
      it.nx = '0; it.ny = '0; it.nz = '0;
    end else if (kind < 8) begin
      // Components between -1.0 and +1.0, as a real renderer would supply.
      it.nx = NORM_W'($signed($urandom_range(0, 32768)) - 16384);
      it.ny = NORM_W'($signed($urandom_range(0, 32768)) - 16384);
      it.nz = NORM_W'($signed($urandom_range(0, 32768)) - 16384);
    end
    it.hx = $urandom;
    it.hy = $urandom;
    it.hz = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      // Hits close to the origin, within -4.0 to +4.0 on each axis.
      it.hx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.hy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.hz = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    end
    return it;
  endfunction

  // Offers one transaction from the current rising edge until it is accepted,
  // then leaves a random gap. Returns on a rising edge.
  task automatic offer_hit(hit_item_t it, bit typed, tex_coord_t want);
    int gap;
    in_valid    <= 1'b1;
    in_normal_x <= it.nx;
    in_normal_y <= it.ny;
    in_normal_z <= it.nz;
    in_hit_x    <= it.hx;
    in_hit_y    <= it.hy;
    in_hit_z    <= it.hz;
    do @(posedge clk); while (in_stall);
    coords_owed.push_back(typed ? want : map_hit(it, tile_now));
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for the pipeline to empty, then writes the tile size.
  task automatic set_tile(logic [TILE_W-1:0] value);
    in_valid <= 1'b0;
    while (coords_owed.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tile_now = value;
    @(posedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off once traffic is under
  // way so that the pipeline fills and pushes back on the input.
  initial begin : stall_gen
    int  len;
    bit  held;
    held = 1'b0;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      len = pick_gap();
      out_stall <= (len > 0);
      if (len > 1) repeat (len - 1) @(posedge clk);
    end
  end

  // Every accepted output transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    tex_coord_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (coords_owed.size() == 0) begin
        $display("%0t: unexpected output u=%0d v=%0d zero=%0b", $time,
                 out_tex_u, out_tex_v, out_zero_normal);
        n_errors++;
      end else begin
        exp_c = coords_owed.pop_front();
        n_checked++;
        if (out_tex_u !== exp_c.u) begin
          $display("%0t: tex_u expected %0d actual %0d", $time, exp_c.u, out_tex_u);
          n_errors++;
        end
        if (out_tex_v !== exp_c.v) begin
          $display("%0t: tex_v expected %0d actual %0d", $time, exp_c.v, out_tex_v);
          n_errors++;
        end
        if (out_zero_normal !== exp_c.zero) begin
          $display("%0t: zero_normal expected %0b actual %0b", $time, exp_c.zero,
                   out_zero_normal);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_MAX) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               coords_owed.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : main_seq
    plane_row_t        rows[$];
    plane_row_t        row;
    tex_coord_t        none;
    logic [TILE_W-1:0] tiles[$];
    hit_item_t         it;
    none = '{u: '0, v: '0, zero: 1'b0};

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_normal_x = '0; in_normal_y = '0; in_normal_z = '0;
    in_hit_x    = '0; in_hit_y    = '0; in_hit_z    = '0;
    n_sent = 0;
    tile_now = TILE_RESET;

    // Directed table; the hand-typed rows assume the reset tile size of 3.0.
    // A zero normal flags and zeroes the coordinates whatever the hit.
    rows.push_back('{'{0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1,
                     '{0, 0, 1}});
    rows.push_back('{'{0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1,
                     '{0, 0, 1}});
    // Normal along +z: u runs along -x, so half a tile gives a half fraction.
    rows.push_back('{'{0, 0, 16384, 98304, 0, 0}, 1, '{32768, 0, 0}});
    // Normal along -z with the hit at the origin.
    rows.push_back('{'{0, 0, -16384, 0, 0, 0}, 1, '{0, 0, 0}});
    // A whole tile along v truncates to a zero fraction.
    rows.push_back('{'{0, 0, 16384, 0, 196608, 0}, 1, '{0, 0, 0}});
    // The remaining rows go through the predictor.
    rows.push_back('{'{0, 0, -16384, 65536, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0}, 0, none});
    rows.push_back('{'{0, 0, 16'sh8000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1}, 0, none});
    rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 0, none});
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, none});
    rows.push_back('{'{16'sh7FFF, 16'sh8000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh7FFF_FFFF}, 0, none});
    rows.push_back('{'{16384, 0, 0, 1000, 2000, 3000}, 0, none});
    rows.push_back('{'{0, -16384, 0, -70000, 123456, -5}, 0, none});
    rows.push_back('{'{9459, 9459, 9459, 300000, -300000, 150000}, 0, none});
    rows.push_back('{'{1, 0, 0, 65536, 65536, 65536}, 0, none});
    rows.push_back('{'{0, 1, -1, -1, 1, -1}, 0, none});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      offer_hit(row.item, row.typed, row.want);
    end

    // Reset value first, then the extremes, zero, and two random sizes.
    tiles.push_back(TILE_RESET);
    tiles.push_back(TILE_MIN);
    tiles.push_back(16'hFFFF);
    tiles.push_back(16'h0000);
    tiles.push_back(16'($urandom_range(1, 4095)));
    tiles.push_back(16'($urandom_range(1, 65535)));
    foreach (tiles[p]) begin
      set_tile(tiles[p]);
      repeat (RAND_ITEMS) begin
        it = random_hit();
        offer_hit(it, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (coords_owed.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d hits over %0d tile sizes, %0d results checked, %0d mismatches.",
             n_sent, tiles.size(), n_checked, n_errors);
    if (n_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ptcm_pkg.sv
hw/rtl/ptcm_isqrt_pipe.sv
hw/rtl/ptcm_div_pipe.sv
hw/rtl/planar_texture_coord_map.sv
hw/rtl/ptcm_checker.sv
dv/tb_planar_texture_coord_map.sv
